/* rtl/core/morse_key_decoder_unit_defines.svh */
// Assertion macros shared by the morse key decoder checkers.
`ifndef MORSE_KEY_DECODER_UNIT_DEFINES_SVH
`define MORSE_KEY_DECODER_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define MKD_CHECK(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("mkd check failed");

// Check a property on every clock edge, reset included.
`define MKD_CHECK_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) (prop)) \
      else $error("mkd check failed");

`endif

/* rtl/core/mkd_pkg.sv */
// Shared types, constants and the symbol table of the morse key decoder.
package mkd_pkg;

   localparam int ELAPSED_BITS_DEFAULT = 16;

   localparam int CSR_INDEX_BITS = 8;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_DOT_LIMIT    = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LETTER_GAP   = 8'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BREAK_GAP    = 8'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SETTLE_TICKS = 8'd3;

   localparam logic [15:0] DOT_LIMIT_RESET    = 16'd200;
   localparam logic [15:0] LETTER_GAP_RESET   = 16'd600;
   localparam logic [15:0] BREAK_GAP_RESET    = 16'd1400;
   localparam logic [7:0]  SETTLE_TICKS_RESET = 8'd10;

   localparam logic [1:0] KIND_CHAR    = 2'd0;
   localparam logic [1:0] KIND_UNKNOWN = 2'd1;
   localparam logic [1:0] KIND_WORD    = 2'd2;

   localparam logic [6:0] SYMBOL_UNKNOWN = 7'h3F;
   localparam logic [6:0] SYMBOL_NONE    = 7'h00;
   localparam logic [2:0] MARK_COUNT_MAX = 3'd6;
   localparam logic [2:0] MARK_COUNT_TOP = 3'd5;

   typedef struct packed {
      logic [15:0] dot_limit;
      logic [15:0] letter_gap;
      logic [15:0] break_gap;
      logic [7:0]  settle_ticks;
   } mkd_cfg_type;

   typedef struct packed {
      logic [1:0] event_kind;
      logic [6:0] symbol_code;
   } mkd_result_type;

   typedef struct packed {
      logic           valid;
      mkd_result_type result;
   } mkd_step_out_type;

   // Key is mark count in bits 7..5 and marks in bits 4..0, newest in bit 0.
   function automatic logic [6:0] symbol_lookup(input logic [7:0] code);
      logic [6:0] sym;
      case (code)
         8'h41: sym = 7'h41; // A
         8'h88: sym = 7'h42; // B
         8'h8A: sym = 7'h43; // C
         8'h64: sym = 7'h44; // D
         8'h20: sym = 7'h45; // E
         8'h82: sym = 7'h46; // F
         8'h66: sym = 7'h47; // G
         8'h80: sym = 7'h48; // H
         8'h40: sym = 7'h49; // I
         8'h87: sym = 7'h4A; // J
         8'h65: sym = 7'h4B; // K
         8'h84: sym = 7'h4C; // L
         8'h43: sym = 7'h4D; // M
         8'h42: sym = 7'h4E; // N
         8'h67: sym = 7'h4F; // O
         8'h86: sym = 7'h50; // P
         8'h8D: sym = 7'h51; // Q
         8'h62: sym = 7'h52; // R
         8'h60: sym = 7'h53; // S
         8'h21: sym = 7'h54; // T
         8'h61: sym = 7'h55; // U
         8'h81: sym = 7'h56; // V
         8'h63: sym = 7'h57; // W
         8'h89: sym = 7'h58; // X
         8'h8B: sym = 7'h59; // Y
         8'h8C: sym = 7'h5A; // Z
         8'hAF: sym = 7'h31; // 1
         8'hA7: sym = 7'h32; // 2
         8'hA3: sym = 7'h33; // 3
         8'hA1: sym = 7'h34; // 4
         8'hA0: sym = 7'h35; // 5
         8'hB0: sym = 7'h36; // 6
         8'hB8: sym = 7'h37; // 7
         8'hBC: sym = 7'h38; // 8
         8'hBE: sym = 7'h39; // 9
         8'hBF: sym = 7'h30; // 0
         default: sym = SYMBOL_NONE;
      endcase
      return sym;
   endfunction

endpackage

/* rtl/core/mkd_csr.sv */
// Configuration registers of the morse key decoder.
module mkd_csr import mkd_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output mkd_cfg_type               cfg
);

   mkd_cfg_type cfg_ff;
   mkd_cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_DOT_LIMIT:    cfg_in.dot_limit    = csr_wdata;
            CSR_LETTER_GAP:   cfg_in.letter_gap   = csr_wdata;
            CSR_BREAK_GAP:    cfg_in.break_gap    = csr_wdata;
            CSR_SETTLE_TICKS: cfg_in.settle_ticks = csr_wdata[7:0];
            default:          cfg_in = cfg_ff; // drop writes to unknown indexes
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dot_limit    <= DOT_LIMIT_RESET;
         cfg_ff.letter_gap   <= LETTER_GAP_RESET;
         cfg_ff.break_gap    <= BREAK_GAP_RESET;
         cfg_ff.settle_ticks <= SETTLE_TICKS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* rtl/core/mkd_step.sv */
// Per-tick decoder state and next-state logic of the morse key decoder.
module mkd_step import mkd_pkg::*; #(
   parameter int ELAPSED_BITS = ELAPSED_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic             key_released,
   input  mkd_cfg_type      cfg,
   output mkd_step_out_type step_out
);

   localparam int CMP_BITS = (ELAPSED_BITS > 16) ? ELAPSED_BITS : 16;

   logic                    prev_level_ff,    prev_level_in;
   logic [7:0]              settle_count_ff,  settle_count_in;
   logic [ELAPSED_BITS-1:0] elapsed_ticks_ff, elapsed_ticks_in;
   logic [4:0]              mark_bits_ff,     mark_bits_in;
   logic [2:0]              mark_count_ff,    mark_count_in;
   logic                    break_done_ff,    break_done_in;

   always_comb begin
      logic [ELAPSED_BITS-1:0] elapsed_next;
      logic                    dash;
      logic [6:0]              sym;

      prev_level_in    = prev_level_ff;
      settle_count_in  = settle_count_ff;
      elapsed_ticks_in = elapsed_ticks_ff;
      mark_bits_in     = mark_bits_ff;
      mark_count_in    = mark_count_ff;
      break_done_in    = break_done_ff;
      step_out         = '0;

      // saturating tick count
      elapsed_next = (elapsed_ticks_ff == '1) ? elapsed_ticks_ff
                                              : elapsed_ticks_ff + 1'b1;
      dash = (CMP_BITS'(elapsed_next) > CMP_BITS'(cfg.dot_limit));
      sym  = symbol_lookup({mark_count_ff, mark_bits_ff});

      if (accept) begin
         elapsed_ticks_in = elapsed_next;
         if (settle_count_ff != 8'd0) begin
            // settle lockout: ignore the sample, keep time running
            settle_count_in = settle_count_ff - 8'd1;
         end else begin
            if (!key_released && prev_level_ff) begin
               elapsed_ticks_in = '0;
               break_done_in    = 1'b0;
               settle_count_in  = cfg.settle_ticks;
            end else if (key_released && !prev_level_ff) begin
               mark_bits_in     = {mark_bits_ff[3:0], dash};
               mark_count_in    = (mark_count_ff < MARK_COUNT_MAX) ? mark_count_ff + 3'd1
                                                                   : mark_count_ff;
               elapsed_ticks_in = '0;
               settle_count_in  = cfg.settle_ticks;
            end
            prev_level_in = key_released;

            if (key_released) begin
               if (mark_count_in != 3'd0
                   && CMP_BITS'(elapsed_ticks_in) >= CMP_BITS'(cfg.letter_gap)) begin
                  sym = symbol_lookup({mark_count_in, mark_bits_in});
                  step_out.valid = 1'b1;
                  if (sym != SYMBOL_NONE && mark_count_in <= MARK_COUNT_TOP) begin
                     step_out.result.event_kind  = KIND_CHAR;
                     step_out.result.symbol_code = sym;
                  end else begin
                     step_out.result.event_kind  = KIND_UNKNOWN;
                     step_out.result.symbol_code = SYMBOL_UNKNOWN;
                  end
                  mark_bits_in     = 5'd0;
                  mark_count_in    = 3'd0;
                  elapsed_ticks_in = '0;
                  break_done_in    = 1'b0;
               end else if (!break_done_in && mark_count_in == 3'd0
                            && CMP_BITS'(elapsed_ticks_in) >= CMP_BITS'(cfg.break_gap)) begin
                  step_out.valid              = 1'b1;
                  step_out.result.event_kind  = KIND_WORD;
                  step_out.result.symbol_code = SYMBOL_NONE;
                  break_done_in               = 1'b1;
                  elapsed_ticks_in            = '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_level_ff    <= 1'b1;
         settle_count_ff  <= 8'd0;
         elapsed_ticks_ff <= '0;
         mark_bits_ff     <= 5'd0;
         mark_count_ff    <= 3'd0;
         break_done_ff    <= 1'b1;
      end else begin
         prev_level_ff    <= prev_level_in;
         settle_count_ff  <= settle_count_in;
         elapsed_ticks_ff <= elapsed_ticks_in;
         mark_bits_ff     <= mark_bits_in;
         mark_count_ff    <= mark_count_in;
         break_done_ff    <= break_done_in;
      end
   end

endmodule

/* rtl/core/mkd_rsp_queue.sv */
// Two-entry result queue that parts the decoder from the result channel.
module mkd_rsp_queue import mkd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  mkd_result_type push_data,
   output logic           full,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output mkd_result_type rsp_data
);

   logic [1:0]     count_ff, count_in;
   logic           head_ff,  head_in;
   mkd_result_type slot_ff [2];
   logic           pop;
   logic           tail;

   assign pop       = rsp_valid && !rsp_stall;
   assign tail      = head_ff ^ count_ff[0];
   assign full      = count_ff[1];
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = slot_ff[head_ff];

   always_comb begin
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
      head_in  = head_ff ^ pop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         head_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         head_ff  <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[tail] <= push_data;
      end
   end

endmodule

/* rtl/core/morse_key_decoder_unit.sv */
// Top level of the morse key decoder.
// Decodes one key sample per clock while req_stall is low: an item is taken
// every such cycle, and any letter, unknown code or word break it causes
// enters a two-entry queue, shown once older results leave; req_stall rises
// only while both entries wait to be taken, so the sustained rate is one item
// per cycle as long as results are drained. Configuration writes are taken
// in any cycle (csr_ready is always high) and should be made while idle.
// No clearing pass follows reset.
module morse_key_decoder_unit import mkd_pkg::*; #(
   parameter int ELAPSED_BITS = ELAPSED_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_key_released,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_event_kind,
   output logic [6:0]                rsp_symbol_code,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   mkd_cfg_type      cfg;
   mkd_step_out_type step_out;
   mkd_result_type   rsp_data;
   logic             full;
   logic             accept;

   assign req_stall       = full;
   assign accept          = req_valid && !full;
   assign rsp_event_kind  = rsp_data.event_kind;
   assign rsp_symbol_code = rsp_data.symbol_code;

   mkd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mkd_step #(
      .ELAPSED_BITS (ELAPSED_BITS)
   ) u_step (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .key_released (req_key_released),
      .cfg          (cfg),
      .step_out     (step_out)
   );

   mkd_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (step_out.valid),
      .push_data (step_out.result),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* rtl/core/mkd_checker.sv */
// Port-level checker of the morse key decoder and its bind.
`include "morse_key_decoder_unit_defines.svh"

module mkd_checker import mkd_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_event_kind,
   input logic [6:0] rsp_symbol_code
);

   logic       word_shown;
   logic       unknown_shown;
   logic [8:0] rsp_payload;

   assign word_shown    = rsp_valid && (rsp_event_kind == KIND_WORD);
   assign unknown_shown = rsp_valid && (rsp_event_kind == KIND_UNKNOWN);
   assign rsp_payload   = {rsp_event_kind, rsp_symbol_code};

   // queue comes out of reset empty and open
   `MKD_CHECK(chk_reset_empty, $past(reset) |-> (!rsp_valid && !req_stall))
   // a word break carries no symbol
   `MKD_CHECK(chk_word_symbol, word_shown |-> (rsp_symbol_code == SYMBOL_NONE))
   // an unknown code always shows the question mark
   `MKD_CHECK(chk_unknown_symbol, unknown_shown |-> (rsp_symbol_code == SYMBOL_UNKNOWN))
   // a stalled result holds
   `MKD_CHECK(chk_rsp_hold, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_payload)))
   // input only stalls while a result waits
   `MKD_CHECK_ALWAYS(chk_stall_waits, req_stall |-> rsp_valid)

endmodule

bind morse_key_decoder_unit mkd_checker u_mkd_checker (.*);

/* tb/sv/tb_top.sv */
// Self-checking testbench for the morse key decoder: key samples in, decoded events out.
`timescale 1ns / 100ps

module tb_top;
   import mkd_pkg::*;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNMAPPED = 8'hFF;
   localparam int IDLE_PCT = 29;
   localparam int REPORT_CAP = 100;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   logic req_stall;
   logic req_key_released = 1'b1;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_event_kind;
   logic [6:0] rsp_symbol_code;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   morse_key_decoder_unit uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_key_released(req_key_released),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_event_kind(rsp_event_kind),
      .rsp_symbol_code(rsp_symbol_code),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Key levels waiting to be sent, and decoded events not yet seen.
   logic key_queue[$];
   mkd_result_type pending_events[$];

   int unsigned keys_queued = 0;
   int unsigned keys_taken = 0;
   int unsigned mismatch_count = 0;
   bit steady_send = 1'b0;
   bit steady_sink = 1'b0;

   // Decoder mirror: configuration and state.
   mkd_cfg_type cfg = '{dot_limit: DOT_LIMIT_RESET, letter_gap: LETTER_GAP_RESET,
                        break_gap: BREAK_GAP_RESET, settle_ticks: SETTLE_TICKS_RESET};
   logic        lvl_prev = 1'b1;
   logic [7:0]  settle_left = '0;
   logic [15:0] elapsed = '0;
   logic [4:0]  marks = '0;
   logic [2:0]  mark_cnt = '0;
   logic        brk_done = 1'b1;

   // Dots and dashes of A-Z, then 0-9, oldest mark first.
   string morse_pattern [36] = '{
      ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
      "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
      "..-", "...-", ".--", "-..-", "-.--", "--..",
      "-----", ".----", "..---", "...--", "....-", ".....", "-....", "--...",
      "---..", "----."};

   function automatic logic [6:0] morse_letter(input logic [4:0] bits,
                                                input logic [2:0] count);
      string glyphs;
      logic [4:0] code;
      logic [6:0] found;
      glyphs = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
      found = SYMBOL_NONE;
      for (int i = 0; i < 36; i++) begin
         if (morse_pattern[i].len() == int'(count)) begin
            code = '0;
            for (int j = 0; j < morse_pattern[i].len(); j++)
               code = {code[3:0], morse_pattern[i][j] == "-"};
            if (code == bits) found = 7'(glyphs[i]);
         end
      end
      return found;
   endfunction

   // Advance the mirror by one key sample and queue any event it causes.
   task automatic decode_tick(input logic key);
      mkd_result_type ev;
      logic [6:0] sym;
      if (elapsed != '1) elapsed++;
      if (settle_left != '0) begin
         settle_left--;
         return;
      end
      if (!key && lvl_prev) begin
         elapsed = '0;
         brk_done = 1'b0;
         settle_left = cfg.settle_ticks;
      end else if (key && !lvl_prev) begin
         marks = {marks[3:0], elapsed > cfg.dot_limit};
         if (mark_cnt < MARK_COUNT_MAX) mark_cnt++;
         elapsed = '0;
         settle_left = cfg.settle_ticks;
      end
      lvl_prev = key;
      if (key) begin
         if (mark_cnt != '0 && elapsed >= cfg.letter_gap) begin
            sym = morse_letter(marks, mark_cnt);
            if (sym != SYMBOL_NONE) begin
               ev.event_kind = KIND_CHAR;
               ev.symbol_code = sym;
            end else begin
               ev.event_kind = KIND_UNKNOWN;
               ev.symbol_code = SYMBOL_UNKNOWN;
            end
            pending_events.push_back(ev);
            marks = '0;
            mark_cnt = '0;
            elapsed = '0;
            brk_done = 1'b0;
         end else if (!brk_done && mark_cnt == '0 && elapsed >= cfg.break_gap) begin
            ev.event_kind = KIND_WORD;
            ev.symbol_code = SYMBOL_NONE;
            pending_events.push_back(ev);
            brk_done = 1'b1;
            elapsed = '0;
         end
      end
   endtask

   task automatic flag_mismatch(input string what);
      if (mismatch_count < REPORT_CAP) $display("mismatch at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   // Sender: hold a stalled item, otherwise advance or idle at random.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            decode_tick(req_key_released);
            keys_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (key_queue.size() != 0 && (steady_send || $urandom_range(99) >= IDLE_PCT)) begin
               req_valid <= 1'b1;
               req_key_released <= key_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: compare each event taken with the oldest one predicted.
   always @(posedge clock) begin
      mkd_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_events.size() == 0) begin
               flag_mismatch($sformatf("unexpected event kind %0d symbol %h",
                                       rsp_event_kind, rsp_symbol_code));
            end else begin
               want = pending_events.pop_front();
               if (rsp_event_kind !== want.event_kind)
                  flag_mismatch($sformatf("event_kind %0d, want %0d",
                                          rsp_event_kind, want.event_kind));
               if (rsp_symbol_code !== want.symbol_code)
                  flag_mismatch($sformatf("symbol_code %h, want %h",
                                          rsp_symbol_code, want.symbol_code));
            end
         end
         rsp_stall <= !steady_sink && ($urandom_range(99) < IDLE_PCT);
      end
   end

   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_DOT_LIMIT:    cfg.dot_limit = data;
         CSR_LETTER_GAP:   cfg.letter_gap = data;
         CSR_BREAK_GAP:    cfg.break_gap = data;
         CSR_SETTLE_TICKS: cfg.settle_ticks = data[7:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   task automatic configure(input int dot, input int chr, input int word, input int settle);
      csr_write(CSR_DOT_LIMIT, 16'(dot));
      csr_write(CSR_LETTER_GAP, 16'(chr));
      csr_write(CSR_BREAK_GAP, 16'(word));
      csr_write(CSR_SETTLE_TICKS, 16'(settle));
   endtask

   // Wait until every sample is taken and every event seen, then let the pipe empty.
   task automatic wait_quiet();
      do @(posedge clock); while (keys_taken != keys_queued || pending_events.size() != 0);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic push_level(input logic level, input int count);
      repeat (count) begin
         key_queue.push_back(level);
         keys_queued++;
      end
   endtask

   // One character of random marks with timing around the current limits.
   task automatic queue_letter();
      int n, dot, len;
      n = ($urandom_range(9) == 0) ? 6 + $urandom_range(1) : 1 + $urandom_range(4);
      dot = (cfg.dot_limit > 1) ? int'(cfg.dot_limit) : 1;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(1))
            len = int'(cfg.dot_limit) + 1 + $urandom_range(3);
         else
            len = 1 + $urandom_range(dot - 1);
         push_level(1'b0, len);
         if (i != n - 1)
            push_level(1'b1, 1 + $urandom_range(cfg.letter_gap > 2 ? cfg.letter_gap - 2 : 0));
      end
      push_level(1'b1, int'(cfg.letter_gap) + 1 + $urandom_range(3));
      if ($urandom_range(2) == 0)
         push_level(1'b1, int'(cfg.break_gap) + 1 + $urandom_range(3));
   endtask

   task automatic queue_noise();
      repeat (1 + $urandom_range(7)) push_level(1'($urandom_range(1)), 1 + $urandom_range(3));
   endtask

   initial begin
      int unsigned first_key, phase;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset values: a press one tick past the dot limit, a gap too short to end it.
      push_level(1'b0, 201);
      push_level(1'b1, 12);
      wait_quiet();

      // Directed: pending dash, dash, word break, too many marks, an unlisted code.
      csr_write(CSR_UNMAPPED, 16'hFFFF);
      configure(1, 1, 2, 0);
      push_level(1'b1, 1);
      push_level(1'b0, 2);
      push_level(1'b1, 4);
      repeat (6) begin
         push_level(1'b0, 1);
         push_level(1'b1, 1);
      end
      push_level(1'b1, 1);
      push_level(1'b0, 1); push_level(1'b1, 1);
      push_level(1'b0, 1); push_level(1'b1, 1);
      push_level(1'b0, 2); push_level(1'b1, 1);
      push_level(1'b0, 2); push_level(1'b1, 2);
      wait_quiet();

      // Zero limits: every press a dash, gaps emit at once.
      configure(0, 0, 0, 0);
      repeat (4) queue_letter();
      wait_quiet();

      configure(1, 1, 1, 0);
      repeat (4) queue_letter();
      wait_quiet();

      // Random part.
      first_key = keys_queued;
      phase = 0;
      while (phase < 4 || keys_queued - first_key < 240) begin
         configure(1 + $urandom_range(5), 1 + $urandom_range(11), 1 + $urandom_range(29),
                   ($urandom_range(4) == 0) ? $urandom_range(10) : $urandom_range(3));
         steady_send = (phase == 2);
         steady_sink = (phase == 2);
         for (int i = 0; i < 2; i++) begin
            if ($urandom_range(4) == 0) queue_noise();
            else queue_letter();
            // Hold the sender until the decoder has caught up.
            if (phase == 1 && i == 0) wait_quiet();
         end
         wait_quiet();
         phase++;
      end

      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/mkd_pkg.sv
rtl/core/mkd_csr.sv
rtl/core/mkd_step.sv
rtl/core/mkd_rsp_queue.sv
rtl/core/morse_key_decoder_unit.sv
rtl/core/mkd_checker.sv
tb/sv/tb_top.sv
